@@ sv/isp_pkg.sv @@
package isp_pkg;

    localparam int MAX_FRAMES  = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W       = 13;
    localparam int STEP_W      = 20;
    localparam int POS_W       = CNT_W + FRAC_BITS;
    localparam int SAMPLE_W    = 16;
    localparam int DELTA_W     = 21;
    localparam int SEEK_W      = DELTA_W + FRAC_BITS + 1;
    localparam int FUNC_W      = 3;
    localparam int INDEX_W     = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEEK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_START = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;

    // one classified item on its way from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0]  left_a;
        logic [SAMPLE_W-1:0]  left_b;
        logic [SAMPLE_W-1:0]  right_a;
        logic [SAMPLE_W-1:0]  right_b;
        logic [FRAC_BITS-1:0] frac;
        logic                 play;
        logic                 playing;
        logic [CNT_W-1:0]     pos;
    } t_entry;

endpackage

@@ sv/isp_ram.sv @@
module isp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ sv/isp_front.sv @@
module isp_front import isp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic [INDEX_W-1:0]         i_frame_index,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic signed [DELTA_W-1:0]  i_seek_delta,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [QCNT_W-1:0]          i_queue_count,
    output logic                       o_push,
    output t_entry                     o_entry
);

    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_frame_count;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_running, n_running;

    logic                 r_s1_valid;
    logic                 r_s1_play;
    logic [FRAC_BITS-1:0] r_s1_frac;
    logic                 r_s1_playing;
    logic [CNT_W-1:0]     r_s1_pos;

    logic                      acc;
    logic [CNT_W-1:0]          frames;
    logic [POS_W-1:0]          end_pos;
    logic [CNT_W-1:0]          i0, i0_inc, i1;
    logic                      tick_play;
    logic [POS_W-1:0]          adv;
    logic [SEEK_W-1:0]         seek_sum;
    logic                      we;
    logic [2*SAMPLE_W-1:0]     rdata_a, rdata_b;

    assign o_cfg_ready = 1'b1;
    assign o_ready = (i_queue_count + QCNT_W'(r_s1_valid)) < QCNT_W'(QUEUE_DEPTH);
    assign acc = i_valid && o_ready;

    always_comb begin
        frames    = (r_frame_count > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : r_frame_count;
        end_pos   = {frames, {FRAC_BITS{1'b0}}};
        i0        = r_pos[POS_W-1:FRAC_BITS];
        i0_inc    = i0 + 1'b1;
        i1        = (i0_inc < frames) ? i0_inc : i0;
        tick_play = r_running && (r_pos < end_pos);
        adv       = r_pos + POS_W'(r_step);
        seek_sum  = {{(SEEK_W-POS_W){1'b0}}, r_pos}
                  + {{(SEEK_W-DELTA_W-FRAC_BITS){i_seek_delta[DELTA_W-1]}},
                     i_seek_delta, {FRAC_BITS{1'b0}}};

        n_pos     = r_pos;
        n_running = r_running;
        we        = 1'b0;
        if (acc) begin
            case (i_func)
                FUNC_LOAD: begin
                    we = 1'b1;
                end
                FUNC_TICK: begin
                    if (tick_play) begin
                        if (adv >= end_pos) begin
                            n_pos     = end_pos;
                            n_running = 1'b0;
                        end else begin
                            n_pos = adv;
                        end
                    end
                end
                FUNC_SEEK: begin
                    if (frames != '0) begin
                        n_running = 1'b1;
                        if (seek_sum[SEEK_W-1]) begin
                            n_pos = '0;
                        end else if (seek_sum >= SEEK_W'(end_pos)) begin
                            n_pos = {frames - 1'b1, {FRAC_BITS{1'b0}}};
                        end else begin
                            n_pos = seek_sum[POS_W-1:0];
                        end
                    end
                end
                FUNC_START: begin
                    n_pos     = '0;
                    n_running = 1'b1;
                end
                FUNC_STOP: begin
                    n_pos     = '0;
                    n_running = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // both channels share one word: left high, right low
    isp_ram #(
        .WIDTH (2*SAMPLE_W),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (i_frame_index[ADDR_W-1:0]),
        .i_wdata   ({i_left_sample, i_right_sample}),
        .i_raddr_a (i0[ADDR_W-1:0]),
        .i_raddr_b (i1[ADDR_W-1:0]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= STEP_RESET;
            r_frame_count <= '0;
            r_pos         <= '0;
            r_running     <= 1'b0;
            r_s1_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STEP_RATE:   r_step        <= i_cfg_data[STEP_W-1:0];
                    CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_pos      <= n_pos;
            r_running  <= n_running;
            r_s1_valid <= acc;
        end
        r_s1_play    <= (i_func == FUNC_TICK) && tick_play;
        r_s1_frac    <= r_pos[FRAC_BITS-1:0];
        r_s1_playing <= n_running;
        r_s1_pos     <= n_pos[POS_W-1:FRAC_BITS];
    end

    assign o_push          = r_s1_valid;
    assign o_entry.left_a  = rdata_a[2*SAMPLE_W-1:SAMPLE_W];
    assign o_entry.right_a = rdata_a[SAMPLE_W-1:0];
    assign o_entry.left_b  = rdata_b[2*SAMPLE_W-1:SAMPLE_W];
    assign o_entry.right_b = rdata_b[SAMPLE_W-1:0];
    assign o_entry.frac    = r_s1_frac;
    assign o_entry.play    = r_s1_play;
    assign o_entry.playing = r_s1_playing;
    assign o_entry.pos     = r_s1_pos;

    a_tick_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_func == FUNC_TICK) && tick_play)
        |=> (r_running ? (r_pos < end_pos) : (r_pos == end_pos)))
        else $error("tick left position past end or flag inconsistent");

    a_seek_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_func == FUNC_SEEK) && (frames != '0))
        |=> (r_running && (r_pos < end_pos)))
        else $error("seek left position outside the clip");

endmodule

@@ sv/isp_queue.sv @@
module isp_queue import isp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_entry            i_entry,
    input  logic              i_pop,
    output logic              o_not_empty,
    output logic [QCNT_W-1:0] o_count,
    output t_entry            o_head
);

    t_entry            r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    assign o_not_empty = (r_count != '0);
    assign o_count     = r_count;
    assign o_head      = r_slot[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

endmodule

@@ sv/isp_back.sv @@
module isp_back import isp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  t_entry                     i_entry,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_left_out,
    output logic signed [SAMPLE_W-1:0] o_right_out,
    output logic                       o_playing,
    output logic [CNT_W-1:0]           o_position_frame
);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int SUM_W  = SAMPLE_W + 2;

    logic                      r_m_valid;
    logic signed [PROD_W-1:0]  r_m_prod_l, r_m_prod_r;
    logic [SAMPLE_W-1:0]       r_m_a_l, r_m_a_r;
    logic                      r_m_play;
    logic                      r_m_playing;
    logic [CNT_W-1:0]          r_m_pos;

    logic                      r_o_valid;

    logic                      m_adv, o_adv;
    logic signed [DIFF_W-1:0]  diff_l, diff_r;
    logic signed [DIFF_W:0]    frac_s;
    logic signed [PROD_W-1:0]  prod_l, prod_r;
    logic signed [PROD_W-1:0]  sh_l, sh_r;
    logic [SUM_W-1:0]          sum_l, sum_r;

    assign o_adv = !r_o_valid || i_ready;
    assign m_adv = !r_m_valid || o_adv;
    assign o_pop = i_valid && m_adv;

    always_comb begin
        diff_l = $signed({i_entry.left_b[SAMPLE_W-1], i_entry.left_b})
               - $signed({i_entry.left_a[SAMPLE_W-1], i_entry.left_a});
        diff_r = $signed({i_entry.right_b[SAMPLE_W-1], i_entry.right_b})
               - $signed({i_entry.right_a[SAMPLE_W-1], i_entry.right_a});
        frac_s = $signed({2'b00, i_entry.frac});
        prod_l = PROD_W'(diff_l * frac_s);
        prod_r = PROD_W'(diff_r * frac_s);
        // floor shift of the weighted difference, then add the lower neighbor
        sh_l   = r_m_prod_l >>> FRAC_BITS;
        sh_r   = r_m_prod_r >>> FRAC_BITS;
        sum_l  = {{2{r_m_a_l[SAMPLE_W-1]}}, r_m_a_l} + sh_l[SUM_W-1:0];
        sum_r  = {{2{r_m_a_r[SAMPLE_W-1]}}, r_m_a_r} + sh_r[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (m_adv) begin
                r_m_valid <= i_valid;
            end
            if (o_adv) begin
                r_o_valid <= r_m_valid;
            end
        end
        if (m_adv) begin
            r_m_prod_l  <= prod_l;
            r_m_prod_r  <= prod_r;
            r_m_a_l     <= i_entry.left_a;
            r_m_a_r     <= i_entry.right_a;
            r_m_play    <= i_entry.play;
            r_m_playing <= i_entry.playing;
            r_m_pos     <= i_entry.pos;
        end
        if (o_adv) begin
            o_left_out       <= r_m_play ? $signed(sum_l[SAMPLE_W-1:0]) : '0;
            o_right_out      <= r_m_play ? $signed(sum_r[SAMPLE_W-1:0]) : '0;
            o_playing        <= r_m_playing;
            o_position_frame <= r_m_pos;
        end
    end

    assign o_valid = r_o_valid;

endmodule

@@ sv/interpolating_sample_player.sv @@
// channel   direction  handshake                  payload
// input     in         i_valid / o_ready          i_func, i_frame_index, i_left_sample,
//                                                 i_right_sample, i_seek_delta
// result    out        o_valid / i_ready          o_left_out, o_right_out, o_playing,
//                                                 o_position_frame
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item per cycle sustained while i_ready stays high; the position update is a single
// add and clamp in the front; each result passes memory read, queue, multiply, final add
// synchronous active-low reset clears position, flag, frame count, valids and queue, sets
// the default step rate; the sample memory is not cleared and needs no clearing pass
// a four-entry queue decouples front and back; o_ready drops only when the queue plus
// the item in the memory read stage would fill it, so a stalled output loses nothing
module interpolating_sample_player import isp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input items
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic [INDEX_W-1:0]         i_frame_index,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic signed [DELTA_W-1:0]  i_seek_delta,
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    // result items
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_left_out,
    output logic signed [SAMPLE_W-1:0] o_right_out,
    output logic                       o_playing,
    output logic [CNT_W-1:0]           o_position_frame
);

    // front to queue
    logic              push;
    t_entry            push_entry;
    // queue to back
    logic              pop;
    logic              not_empty;
    logic [QCNT_W-1:0] queue_count;
    t_entry            head_entry;

    // front: owns play state and config, classifies items, drives the sample memory
    isp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_frame_index  (i_frame_index),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_seek_delta   (i_seek_delta),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_queue_count  (queue_count),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    // short queue holding neighbor samples and result status per item
    isp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_entry     (push_entry),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_count     (queue_count),
        .o_head      (head_entry)
    );

    // back: interpolation multiply, add, output register
    isp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (not_empty),
        .i_entry          (head_entry),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_playing        (o_playing),
        .o_position_frame (o_position_frame)
    );

endmodule

@@ sim/tb_interpolating_sample_player.sv @@
`timescale 1ns / 1ps

module tb_interpolating_sample_player;
    import isp_pkg::*;

    // largest step_rate the tests use, 8 frames per tick
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(524288);
    // cycles with no transfer on any channel before the run is abandoned
    localparam int unsigned STALL_LIMIT = 2000;
    // pipeline depth plus margin, waited out before a register write and at the end
    localparam int unsigned DRAIN_CYCLES = 8;
    // at most how many frames of a clip are written up front before a phase starts playing
    localparam int unsigned PRELOAD_MAX = 48;

    // one input transfer
    typedef struct {
        logic [FUNC_W-1:0]          func;
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic signed [DELTA_W-1:0]  delta;
    } t_player_cmd;

    // one output frame as the block should produce it
    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       playing;
        logic [CNT_W-1:0]           pos;
    } t_frame;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [FUNC_W-1:0]          i_func = FUNC_LOAD;
    logic [INDEX_W-1:0]         i_frame_index = '0;
    logic signed [SAMPLE_W-1:0] i_left_sample = '0;
    logic signed [SAMPLE_W-1:0] i_right_sample = '0;
    logic signed [DELTA_W-1:0]  i_seek_delta = '0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_STEP_RATE;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_left_out;
    logic signed [SAMPLE_W-1:0] o_right_out;
    logic                       o_playing;
    logic [CNT_W-1:0]           o_position_frame;

    interpolating_sample_player dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_frame_index    (i_frame_index),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_seek_delta     (i_seek_delta),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_playing        (o_playing),
        .o_position_frame (o_position_frame)
    );

    // predicted player state, updated as each input transfer is accepted
    logic signed [SAMPLE_W-1:0] left_mem  [MAX_FRAMES];
    logic signed [SAMPLE_W-1:0] right_mem [MAX_FRAMES];
    bit                         written   [MAX_FRAMES];
    longint                     pos_q     = 0;
    bit                         running   = 1'b0;
    logic [STEP_W-1:0]          step_reg  = STEP_RESET;
    logic [CNT_W-1:0]           count_reg = '0;

    t_frame      pending_frames [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned ready_hold     = 0;
    // set per phase to give stretches with no idling on either side
    bit          src_steady  = 1'b0;
    bit          sink_steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint frames_loaded();
        return (count_reg > MAX_FRAMES) ? longint'(MAX_FRAMES) : longint'(count_reg);
    endfunction

    // a + floor((b - a) * t / 2^FRAC_BITS)
    function automatic logic signed [SAMPLE_W-1:0] blend(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic [FRAC_BITS-1:0]       t
    );
        longint prod;
        prod = (longint'(b) - longint'(a)) * longint'(t);
        return SAMPLE_W'(longint'(a) + (prod >>> FRAC_BITS));
    endfunction

    function automatic t_frame advance_player(input t_player_cmd c);
        t_frame                     r;
        longint                     frames;
        longint                     stop_pos;
        longint                     p;
        longint                     i0;
        longint                     i1;
        logic [FRAC_BITS-1:0]       t;
        r.left   = '0;
        r.right  = '0;
        frames   = frames_loaded();
        stop_pos = frames << FRAC_BITS;
        case (c.func)
            FUNC_LOAD: begin
                left_mem[c.index]  = c.left;
                right_mem[c.index] = c.right;
                written[c.index]   = 1'b1;
            end
            FUNC_TICK: begin
                if (running && pos_q < stop_pos) begin
                    i0 = pos_q >> FRAC_BITS;
                    t  = FRAC_BITS'(pos_q);
                    // upper neighbour sticks to the last frame
                    i1 = (i0 + 1 < frames) ? i0 + 1 : i0;
                    r.left  = blend(left_mem[i0], left_mem[i1], t);
                    r.right = blend(right_mem[i0], right_mem[i1], t);
                    pos_q += longint'(step_reg);
                    if (pos_q >= stop_pos) begin
                        pos_q   = stop_pos;
                        running = 1'b0;
                    end
                end
            end
            FUNC_SEEK: begin
                if (frames > 0) begin
                    p = pos_q + longint'(c.delta) * (longint'(1) << FRAC_BITS);
                    if (p < 0) p = 0;
                    if (p >= stop_pos) p = (frames - 1) << FRAC_BITS;
                    pos_q   = p;
                    running = 1'b1;
                end
            end
            FUNC_START: begin
                pos_q   = 0;
                running = 1'b1;
            end
            FUNC_STOP: begin
                pos_q   = 0;
                running = 1'b0;
            end
            default: begin
            end
        endcase
        r.playing = running;
        r.pos     = CNT_W'(pos_q >> FRAC_BITS);
        return r;
    endfunction

    // address a playing tick would read before it was ever loaded, or -1
    function automatic int unread_addr();
        longint frames;
        longint i0;
        longint i1;
        frames = frames_loaded();
        if (!running || pos_q >= (frames << FRAC_BITS)) return -1;
        i0 = pos_q >> FRAC_BITS;
        i1 = (i0 + 1 < frames) ? i0 + 1 : i0;
        if (!written[i0]) return int'(i0);
        if (!written[i1]) return int'(i1);
        return -1;
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_player_cmd rand_cmd(input logic [FUNC_W-1:0] f);
        t_player_cmd c;
        c.func  = f;
        c.index = INDEX_W'($urandom);
        c.left  = SAMPLE_W'($urandom);
        c.right = SAMPLE_W'($urandom);
        c.delta = DELTA_W'($urandom);
        return c;
    endfunction

    // one input transfer; the expected frame is queued on acceptance
    task automatic send_item(input t_player_cmd c);
        if (!src_steady && $urandom_range(99) < 40) begin
            i_valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= c.func;
        i_frame_index  <= c.index;
        i_left_sample  <= c.left;
        i_right_sample <= c.right;
        i_seek_delta   <= c.delta;
        do @(posedge i_clk); while (!o_ready);
        pending_frames.push_back(advance_player(c));
    endtask

    task automatic send_load(input int unsigned addr, input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r);
        t_player_cmd c;
        c       = rand_cmd(FUNC_LOAD);
        c.index = INDEX_W'(addr);
        c.left  = l;
        c.right = r;
        send_item(c);
    endtask

    task automatic send_seek(input int d);
        t_player_cmd c;
        c       = rand_cmd(FUNC_SEEK);
        c.delta = DELTA_W'(d);
        send_item(c);
    endtask

    // block idle: no input pending, every frame back, pipeline flushed
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // both registers back to back, valid held high across the two transfers
    task automatic set_playback(input logic [STEP_W-1:0] step, input logic [CNT_W-1:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_STEP_RATE;
        i_cfg_data  <= CFG_DATA_W'(step);
        do @(posedge i_clk); while (!o_cfg_ready);
        step_reg = step;
        i_cfg_index <= CFG_FRAME_COUNT;
        i_cfg_data  <= CFG_DATA_W'(count);
        do @(posedge i_clk); while (!o_cfg_ready);
        count_reg = count;
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, mostly short
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if (!sink_steady && $urandom_range(99) < 25) begin
            ready_hold <= gap_len() - 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic signed [31:0] expv,
                               input logic signed [31:0] actv);
        if (actv !== expv) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame exp_frame;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_frames.size() == 0) begin
                mismatch_count++;
                $display("%0t: frame with none expected, expected nothing, actual %0d %0d %0b %0d",
                         $time, o_left_out, o_right_out, o_playing, o_position_frame);
            end else begin
                exp_frame = pending_frames.pop_front();
                check_field("left_out", exp_frame.left, o_left_out);
                check_field("right_out", exp_frame.right, o_right_out);
                check_field("playing", exp_frame.playing, o_playing);
                check_field("position_frame", exp_frame.pos, o_position_frame);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- tests

    // reset defaults: no frames, so nothing ever plays
    task automatic test_empty_clip();
        send_item(rand_cmd(FUNC_TICK));
        // start sets the flag even with an empty clip
        send_item(rand_cmd(FUNC_START));
        send_item(rand_cmd(FUNC_TICK));
        // seek is a no-op with no frames
        send_seek(5);
        send_item(rand_cmd(FUNC_STOP));
    endtask

    // four-frame clip at half speed, sample extremes, clamps and spare codes
    task automatic test_directed_clip();
        t_player_cmd c;
        wait_drained();
        set_playback(STEP_W'(32768), CNT_W'(4));
        send_load(0, 16'sh7fff, 16'sh8000);
        send_load(1, 16'sh8000, 16'sh7fff);
        send_load(2, 16'sh0000, 16'shffff);
        send_load(3, 16'shffff, 16'sh0000);
        send_load(MAX_FRAMES - 1, 16'sh5555, 16'shaaaa);
        send_item(rand_cmd(FUNC_START));
        // eight playing ticks run to the end, the ninth finds playback stopped
        repeat (9) send_item(rand_cmd(FUNC_TICK));
        // full-scale seeks clamp to the first and to the last frame
        send_seek(-1048576);
        send_seek(1048575);
        // on the last frame both neighbours are the same frame
        send_item(rand_cmd(FUNC_TICK));
        for (int k = 1; k <= 3; k++) begin
            c = rand_cmd(FUNC_W'(FUNC_STOP + k));
            send_item(c);
        end
        send_item(rand_cmd(FUNC_STOP));
    endtask

    // one register setting, a preload of the clip head, then a random mix
    task automatic run_phase(input logic [STEP_W-1:0] step, input logic [CNT_W-1:0] count,
                             input int unsigned n);
        t_player_cmd c;
        int unsigned pick;
        int unsigned hi;
        int          miss;
        int          span;
        wait_drained();
        set_playback(step, count);
        src_steady  = ($urandom_range(3) == 0);
        sink_steady = ($urandom_range(3) == 0);
        for (int k = 0; k < int'(count) && k < int'(PRELOAD_MAX); k++) begin
            if (!written[k] || $urandom_range(1))
                send_load(k, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end
        hi   = (count == 0) ? 0 : unsigned'(int'(frames_loaded()) - 1);
        span = int'(count) + 2;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                // a burst of ticks, with a never-loaded neighbour filled in first
                repeat ($urandom_range(1, 6)) begin
                    miss = unread_addr();
                    if (miss < 0) send_item(rand_cmd(FUNC_TICK));
                    else send_load(miss, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                end
            end else if (pick < 62) begin
                c = rand_cmd(FUNC_LOAD);
                if ($urandom_range(99) < 80) c.index = INDEX_W'($urandom_range(hi));
                send_item(c);
            end else if (pick < 72) begin
                send_item(rand_cmd(FUNC_START));
            end else if (pick < 82) begin
                c    = rand_cmd(FUNC_SEEK);
                pick = $urandom_range(99);
                if (pick < 60) c.delta = DELTA_W'(int'($urandom_range(2 * span)) - span);
                else if (pick < 70) c.delta = {1'b1, {(DELTA_W - 1){1'b0}}};
                else if (pick < 80) c.delta = {1'b0, {(DELTA_W - 1){1'b1}}};
                send_item(c);
            end else if (pick < 92) begin
                send_item(rand_cmd(FUNC_STOP));
            end else begin
                send_item(rand_cmd(FUNC_W'(FUNC_STOP + $urandom_range(1, 3))));
            end
        end
    endtask

    // step rate at zero, at STEP_MAX and at the smallest fraction
    task automatic test_step_extremes();
        run_phase('0, CNT_W'(3), 30);
        run_phase(STEP_MAX, CNT_W'(MAX_FRAMES), 60);
        run_phase(STEP_W'(1), CNT_W'(2), 30);
    endtask

    // random settings, mostly short clips, a few empty or full-size ones
    task automatic test_random_playback();
        logic [STEP_W-1:0] step;
        logic [CNT_W-1:0]  count;
        int unsigned       r;
        repeat (16) begin
            r = $urandom_range(99);
            if (r < 10) step = '0;
            else if (r < 20) step = STEP_MAX;
            else if (r < 30) step = STEP_W'($urandom_range(1, 255));
            else step = STEP_W'($urandom_range(4096, 3 * 65536));
            r = $urandom_range(99);
            if (r < 10) count = '0;
            else if (r < 20) count = CNT_W'(MAX_FRAMES);
            else if (r < 30) count = CNT_W'($urandom_range(33, MAX_FRAMES - 1));
            else count = CNT_W'($urandom_range(1, 32));
            run_phase(step, count, $urandom_range(12, 22));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_clip();
        test_directed_clip();
        test_step_extremes();
        test_random_playback();
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        wait_drained();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
